// ===== hdl/fhcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame hue colour mark detector package
// Shared payload types, history sizing and hue constants.
// ----------------------------------------------------------------------------
package fhcm_pkg;

    localparam int HISTORY_DEPTH = 512;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int HIST_CW       = $clog2(HISTORY_DEPTH + 1);

    localparam int TIME_W  = 31;
    localparam int HUE_W   = 9;
    localparam int ENTRY_W = 1 + HUE_W + TIME_W;

    localparam int HUE_FULL   = 384;
    localparam int HUE_HALF   = 192;
    localparam int HUE_SECTOR = 64;
    localparam int MARK_STEPS = 6;
    localparam int WINDOW_STEPS = 8;

    localparam logic [1:0] REG_STEP_MS       = 2'd0;
    localparam logic [1:0] REG_FAIL_LIMIT    = 2'd1;
    localparam logic [1:0] REG_HUE_TOLERANCE = 2'd2;

    typedef struct packed {
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic              frame_end;
        logic [TIME_W-1:0] frame_time_ms;
    } t_pixel;

    typedef struct packed {
        logic [HUE_W-1:0]  frame_hue;
        logic              hue_valid;
        logic              mark_found;
        logic [TIME_W-1:0] mark_time_ms;
    } t_result;

endpackage

// ===== hdl/fhcm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module fhcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/frame_hue_color_mark_detector.sv =====
// ----------------------------------------------------------------------------
// Frame hue colour mark detector
// Sums pixel channels per frame, derives the mean hue at frame end, keeps a
// hue history and searches it for the six-step colour mark.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  in        input      i_in_valid / o_in_stall t_pixel, one pixel per request
//  out       output     o_out_valid/i_out_stall t_result, one per frame end
//  cfg       input      APB-style write/read    step_ms, fail_limit, tolerance
//
// A pixel without frame end is added to the running sums. A frame-end request
// computes the hue (seven-step restoring divider), writes the history entry,
// sets up the expected times, then scans the history back for the window,
// compares the entries in it (the oldest entry included), counts misses and
// decides and issues the result.
// Reset is synchronous; clears sums, history, output valid; presets config.
// A result waiting on a stalled output does not block further pixels; only
// the next frame-end result waits for the output register to drain.
module frame_hue_color_mark_detector (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  fhcm_pkg::t_pixel i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output fhcm_pkg::t_result o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import fhcm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MAX, S_PREP, S_DIV, S_HFIN, S_WRITE, S_EXP,
        S_FRD, S_FCHK, S_SRD, S_SCMP, S_EVAL, S_DEC, S_OUT
    } t_state;

    typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} t_sector;

    t_state r_state;

    logic [10:0] r_step_ms;
    logic [2:0]  r_fail_limit;
    logic [7:0]  r_hue_tol;

    logic [31:0] r_sum_b, r_sum_g, r_sum_r;
    logic [31:0] r_b, r_g, r_r;
    logic [TIME_W-1:0] r_last;

    logic [31:0] r_mx, r_mn;
    t_sector     r_sec;
    logic        r_valid;
    logic        r_neg;
    logic [37:0] r_rem;
    logic [31:0] r_div;
    logic [2:0]  r_bit;
    logic [6:0]  r_q;
    logic [9:0]  r_base;
    logic [HUE_W-1:0] r_hue;

    logic [HIST_AW-1:0] r_wpos;
    logic [HIST_CW-1:0] r_count;
    logic [HIST_AW-1:0] r_oldest;
    logic [HIST_AW-1:0] r_idx;
    logic [HIST_AW-1:0] r_first;
    logic               r_zero_pass;

    logic [2:0]         r_k;
    logic signed [33:0] r_exp [MARK_STEPS];
    logic signed [33:0] r_lim;
    logic [33:0]        r_best_dist [MARK_STEPS];
    logic [HUE_W:0]     r_best_hue [MARK_STEPS];
    logic [2:0]         r_misses;

    logic    r_out_valid;
    t_result r_out;
    logic    r_found;
    logic [TIME_W-1:0] r_start;

    // ---------------- handshakes ----------------
    logic in_acc, out_free, cfg_wr;
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_STEP_MS:       prdata = {21'd0, r_step_ms};
            REG_FAIL_LIMIT:    prdata = {29'd0, r_fail_limit};
            REG_HUE_TOLERANCE: prdata = {24'd0, r_hue_tol};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- history RAM ----------------
    logic [HIST_AW:0]   slot_sum;
    logic [HIST_AW-1:0] slot;
    logic               ram_re, ram_we;
    logic [ENTRY_W-1:0] ram_rdata;

    assign slot_sum = {1'b0, r_oldest} + {1'b0, r_idx};
    assign slot = (slot_sum >= (HIST_AW+1)'(HISTORY_DEPTH))
                ? HIST_AW'(slot_sum - (HIST_AW+1)'(HISTORY_DEPTH))
                : slot_sum[HIST_AW-1:0];
    assign ram_re = (r_state == S_FRD && r_idx != '0) || (r_state == S_SRD);
    assign ram_we = (r_state == S_WRITE);

    fhcm_ram #(.WIDTH(ENTRY_W), .DEPTH(HISTORY_DEPTH)) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata ({r_valid, r_hue, r_last}),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    // ---------------- shared datapath pieces ----------------
    logic [31:0] fb, fg, fr;
    assign fb = r_sum_b + 32'(i_in_data.blue);
    assign fg = r_sum_g + 32'(i_in_data.green);
    assign fr = r_sum_r + 32'(i_in_data.red);

    logic [31:0] c_mx, c_mn;
    t_sector     c_sec;
    always_comb begin
        c_mx = (r_b > r_g) ? r_b : r_g;
        if (r_r > c_mx) c_mx = r_r;
        c_mn = (r_b < r_g) ? r_b : r_g;
        if (r_r < c_mn) c_mn = r_r;
        if (c_mx == r_b)      c_sec = SEC_BLUE;
        else if (c_mx == r_g) c_sec = SEC_GREEN;
        else                  c_sec = SEC_RED;
    end

    logic signed [32:0] c_num;
    logic [31:0]        c_mag;
    always_comb begin
        case (r_sec)
            SEC_BLUE:  c_num = $signed({1'b0, r_r}) - $signed({1'b0, r_g});
            SEC_GREEN: c_num = $signed({1'b0, r_b}) - $signed({1'b0, r_r});
            default:   c_num = $signed({1'b0, r_g}) - $signed({1'b0, r_b});
        endcase
        c_mag = c_num[32] ? 32'(-c_num) : c_num[31:0];
    end

    logic [38:0] div_trial;
    assign div_trial = 39'(r_rem) - (39'(r_div) << r_bit);

    logic [6:0]         q_adj;
    logic signed [10:0] h_sum;
    always_comb begin
        q_adj = r_q + 7'((r_neg && r_rem != '0) ? 1 : 0);
        h_sum = $signed({1'b0, r_base}) + (r_neg ? -$signed({4'd0, q_adj})
                                                 : $signed({4'd0, q_adj}));
        if (h_sum < 0) h_sum = h_sum + 11'sd384;
    end

    // Expected time of step k is last - (5-k) * step.
    logic [13:0]        mul_step;
    logic signed [33:0] last_s;
    assign mul_step = 14'(r_step_ms) * 14'(3'd5 - r_k);
    assign last_s   = $signed({3'b000, r_last});

    // One distance compare per cycle while comparing, shared by all steps.
    logic signed [33:0] t_s, diff;
    logic [33:0]        cand_dist;
    assign t_s  = $signed({3'b000, ram_rdata[TIME_W-1:0]});
    assign diff = t_s - r_exp[r_k];
    assign cand_dist = diff[33] ? 34'(-diff) : 34'(diff);

    logic signed [10:0] hd;
    logic               miss;
    always_comb begin
        hd = $signed({2'b00, r_best_hue[r_k][HUE_W-1:0]}) - $signed({2'b00, r_k, 6'd0});
        if (hd > 11'sd192) hd = hd - 11'sd384;
        miss = !r_best_hue[r_k][HUE_W] || hd < -$signed({3'b000, r_hue_tol})
             || hd > $signed({3'b000, r_hue_tol});
    end

    logic signed [33:0] start_s;
    assign start_s = last_s - $signed({20'd0, 14'(r_step_ms) * 14'(MARK_STEPS)});

    logic [HIST_AW+1:0] old_tmp;
    assign old_tmp = (HIST_AW+2)'(r_wpos) + (HIST_AW+2)'(HISTORY_DEPTH)
                   - (HIST_AW+2)'(r_count);

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step_ms    <= 11'd500;
            r_fail_limit <= 3'd3;
            r_hue_tol    <= 8'd32;
            r_sum_b      <= '0;
            r_sum_g      <= '0;
            r_sum_r      <= '0;
            r_wpos       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_STEP_MS:       r_step_ms    <= pwdata[10:0];
                    REG_FAIL_LIMIT:    r_fail_limit <= pwdata[2:0];
                    REG_HUE_TOLERANCE: r_hue_tol    <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.frame_end) begin
                            r_b     <= fb;
                            r_g     <= fg;
                            r_r     <= fr;
                            r_last  <= i_in_data.frame_time_ms;
                            r_sum_b <= '0;
                            r_sum_g <= '0;
                            r_sum_r <= '0;
                            r_state <= S_MAX;
                        end else begin
                            r_sum_b <= fb;
                            r_sum_g <= fg;
                            r_sum_r <= fr;
                        end
                    end
                end
                S_MAX: begin
                    r_mx    <= c_mx;
                    r_mn    <= c_mn;
                    r_sec   <= c_sec;
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_valid <= {1'b0, r_mx} > {r_mn, 1'b0};
                    r_div   <= r_mx - r_mn;
                    r_neg   <= c_num[32];
                    r_rem   <= {c_mag, 6'd0};
                    r_q     <= '0;
                    r_bit   <= 3'd6;
                    r_hue   <= '0;
                    case (r_sec)
                        SEC_BLUE:  r_base <= 10'(4 * HUE_SECTOR);
                        SEC_GREEN: r_base <= 10'(2 * HUE_SECTOR);
                        default:   r_base <= '0;
                    endcase
                    r_state <= ({1'b0, r_mx} > {r_mn, 1'b0}) ? S_DIV : S_WRITE;
                end
                S_DIV: begin
                    if (!div_trial[38]) begin
                        r_rem        <= div_trial[37:0];
                        r_q[r_bit]   <= 1'b1;
                    end
                    r_bit <= r_bit - 3'd1;
                    if (r_bit == 3'd0) r_state <= S_HFIN;
                end
                S_HFIN: begin
                    r_hue   <= h_sum[HUE_W-1:0];
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_wpos <= (r_wpos == HIST_AW'(HISTORY_DEPTH - 1)) ? '0
                                                                       : r_wpos + 1'b1;
                    if (r_count < HIST_CW'(HISTORY_DEPTH)) r_count <= r_count + 1'b1;
                    r_k     <= '0;
                    r_lim   <= last_s - $signed({19'd0, 15'(WINDOW_STEPS * r_step_ms)});
                    r_state <= S_EXP;
                end
                S_EXP: begin
                    r_exp[r_k]       <= last_s - $signed({20'd0, mul_step});
                    r_best_dist[r_k] <= '1;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'(MARK_STEPS - 1)) begin
                        r_oldest <= (old_tmp >= (HIST_AW+2)'(HISTORY_DEPTH))
                                  ? HIST_AW'(old_tmp - (HIST_AW+2)'(HISTORY_DEPTH))
                                  : old_tmp[HIST_AW-1:0];
                        r_idx   <= HIST_AW'(r_count - 1'b1);
                        r_state <= S_FRD;
                    end
                end
                S_FRD: begin
                    if (r_idx == '0) begin
                        r_found <= 1'b0;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_FCHK;
                    end
                end
                S_FCHK: begin
                    if (t_s < r_lim) begin
                        // The window opens here; the oldest entry is visited first.
                        r_first     <= r_idx;
                        r_idx       <= '0;
                        r_zero_pass <= 1'b1;
                        r_state     <= S_SRD;
                    end else begin
                        r_idx   <= r_idx - 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_SRD: begin
                    r_k     <= '0;
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (cand_dist < r_best_dist[r_k]) begin
                        r_best_dist[r_k] <= cand_dist;
                        r_best_hue[r_k]  <= ram_rdata[ENTRY_W-1:TIME_W];
                    end
                    r_k <= (r_k == 3'(MARK_STEPS - 1)) ? '0 : r_k + 3'd1;
                    if (r_k == 3'(MARK_STEPS - 1)) begin
                        if (r_zero_pass) begin
                            r_zero_pass <= 1'b0;
                            r_idx       <= r_first;
                            r_state     <= S_SRD;
                        end else if (r_idx == HIST_AW'(r_count - 1'b1)) begin
                            r_misses <= '0;
                            r_state  <= S_EVAL;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_SRD;
                        end
                    end
                end
                S_EVAL: begin
                    if (miss) r_misses <= r_misses + 3'd1;
                    r_k <= r_k + 3'd1;
                    if (r_k == 3'(MARK_STEPS - 1)) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_found <= r_misses < r_fail_limit;
                    r_start <= start_s[33] ? '0 : start_s[TIME_W-1:0];
                    if (r_misses < r_fail_limit) begin
                        r_count <= '0;
                        r_wpos  <= '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out.frame_hue     <= r_hue;
                        r_out.hue_valid     <= r_valid;
                        r_out.mark_found    <= r_found;
                        r_out.mark_time_ms  <= r_found ? r_start : '0;
                        r_state             <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
